[rtl/core/slcd_pkg.sv]
// Package for the sync/length/CRC deframer: phase type, result record,
// register codes, reset values and the bytewise CRC-16/XMODEM function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } slcd_phase_t;

    typedef enum logic [1:0] {
        CFG_SYNC_WORD = 2'd0,
        CFG_MIN_LEN   = 2'd1,
        CFG_MAX_LEN   = 2'd2
    } slcd_cfg_idx_t;

    localparam int CFG_IDX_W = 2;
    localparam int LEN_REG_W = 21;

    localparam logic [31:0]          SYNC_RESET = 32'hFDB1_8540;
    localparam logic [LEN_REG_W-1:0] MIN_RESET  = 21'd85;
    localparam logic [LEN_REG_W-1:0] MAX_RESET  = 21'd1048576;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // frame layout
    localparam int HDR_LEN      = 8;
    localparam int SYNC_END     = 4;
    localparam int LEN_FLOOR    = 10;
    localparam int CRC_TAIL     = 7;
    localparam int STORED_HI    = 6;
    localparam int STORED_LO    = 5;
    localparam int OFFSET_OUT_W = 20;
    localparam int WIN_BYTES    = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                    kind;
        logic [7:0]              out_byte;
        logic [OFFSET_OUT_W-1:0] byte_offset;
        logic                    last_of_frame;
        logic                    crc_ok;
        logic [31:0]             frame_length;
    } slcd_result_t;

    typedef struct packed {
        logic         valid;
        slcd_result_t data;
    } slcd_push_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sync_length_crc_deframer.sv]
// Sync-word / length / CRC-16 deframer, top level: front end, result queue
// and output packing onto the master stream. Depends on slcd_pkg,
// slcd_front and slcd_queue.
//
// Takes one byte per clock, sustained, on the slave stream while the result
// queue has space, and delivers at most one result per byte on the master
// stream through that queue. The front end does the window shift, length
// check and one bytewise CRC update in the cycle the byte is taken. A
// two-entry result queue sits between the front end and the output, so
// s_tready drops only when both entries are occupied. A rejected length
// shows m_tuser=1 with the length in m_tdata; frame body bytes show
// m_tuser=0, with m_tlast on the final byte carrying the CRC check. Config
// writes are accepted every cycle and take effect once registered.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_crc_deframer #(
    parameter int OFFSET_BITS = 21
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] data_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] out_byte, [27:8] byte_offset, [28] crc_ok, [60:29] frame_length, [63:61] zero
    output logic [63:0]                          m_tdata,
    output logic                                 m_tuser,   // [0] kind
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import slcd_pkg::*;

    slcd_push_t   push;
    logic         space;
    slcd_result_t head;

    slcd_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .space     (space),
        .push      (push),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {3'b000, head.frame_length, head.crc_ok, head.byte_offset, head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_frame;

endmodule

`default_nettype wire

[rtl/core/slcd_front.sv]
// Front end of the deframer: config registers, sync hunt, length check,
// offset counting and CRC. Pushes at most one result per accepted byte.
// Depends on slcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcd_front #(
    parameter int OFFSET_BITS = 21
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            space,
    output slcd_pkg::slcd_push_t                 push,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [slcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import slcd_pkg::*;

    slcd_phase_t              phase_reg, phase_next;
    logic [31:0]              window_reg, window_next;
    logic [31:0]              length_reg, length_next;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [15:0]              crc_reg, crc_next;
    logic [15:0]              stored_reg, stored_next;
    logic [2:0]               biw_reg, biw_next;
    logic [15:0]              run_reg, run_next;
    logic [15:0]              snap1_reg, snap1_next;
    logic [15:0]              snap2_reg, snap2_next;
    logic [15:0]              snap3_reg, snap3_next;

    logic [31:0]              sync_reg;
    logic [LEN_REG_W-1:0]     min_reg;
    logic [LEN_REG_W-1:0]     max_reg;

    logic                     accept;
    logic [31:0]              win_shift;
    logic [OFFSET_BITS-1:0]   offset_inc;
    logic [32:0]              off_wide;
    logic [32:0]              len_wide;
    logic [32:0]              new_len_wide;
    logic [15:0]              crc_in;
    logic [15:0]              crc_step;
    logic                     len_done;
    logic                     len_ok;
    logic                     sync_hit;
    logic                     is_last;
    logic [2:0]               biw_sat;

    assign cfg_ready = 1'b1;
    assign in_ready  = space;
    assign accept    = in_valid && space;

    assign win_shift    = {window_reg[23:0], in_byte};
    assign offset_inc   = offset_reg + 1'b1;
    assign off_wide     = 33'(offset_reg);
    assign len_wide     = 33'(length_reg);
    assign new_len_wide = 33'(win_shift);
    assign crc_in       = (phase_reg == PH_BODY) ? crc_reg : run_reg;
    assign crc_step     = crc16_byte(crc_in, in_byte);
    assign len_done     = (offset_inc == OFFSET_BITS'(HDR_LEN));
    assign len_ok       = (new_len_wide > 33'(min_reg)) && (new_len_wide <= 33'(max_reg))
                          && (new_len_wide >= 33'(LEN_FLOOR))
                          && (new_len_wide <= (33'(1) << OFFSET_BITS));
    assign sync_hit     = (win_shift == sync_reg);
    assign is_last      = ((off_wide + 33'(1)) == len_wide);
    assign biw_sat      = (biw_reg < 3'(WIN_BYTES)) ? biw_reg + 3'd1 : biw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
            min_reg  <= MIN_RESET;
            max_reg  <= MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYNC_WORD: sync_reg <= cfg_data;
                CFG_MIN_LEN:   min_reg  <= cfg_data[LEN_REG_W-1:0];
                CFG_MAX_LEN:   max_reg  <= cfg_data[LEN_REG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (len_done)
                    begin
                        if (len_ok)
                            phase_next = PH_BODY;
                        else if (sync_hit)
                            phase_next = PH_LEN;
                        else
                            phase_next = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (is_last)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = (biw_sat >= 3'(WIN_BYTES) && sync_hit) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        window_next = window_reg;
        length_next = length_reg;
        offset_next = offset_reg;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        biw_next    = biw_reg;
        run_next    = run_reg;
        snap1_next  = snap1_reg;
        snap2_next  = snap2_reg;
        snap3_next  = snap3_reg;
        push        = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    window_next = win_shift;
                    offset_next = offset_inc;
                    run_next    = crc_step;
                    if (offset_inc == OFFSET_BITS'(SYNC_END + 1))
                        snap1_next = crc_step;
                    if (offset_inc == OFFSET_BITS'(SYNC_END + 2))
                        snap2_next = crc_step;
                    if (offset_inc == OFFSET_BITS'(SYNC_END + 3))
                        snap3_next = crc_step;
                    if (len_done)
                    begin
                        length_next = win_shift;
                        if (len_ok)
                        begin
                            // short frames: CRC span and stored CRC overlap the length bytes
                            case (win_shift)
                                32'(LEN_FLOOR):
                                begin
                                    crc_next    = 16'h0000;
                                    stored_next = win_shift[31:16];
                                end
                                32'(LEN_FLOOR + 1):
                                begin
                                    crc_next    = snap1_reg;
                                    stored_next = win_shift[23:8];
                                end
                                32'(LEN_FLOOR + 2):
                                begin
                                    crc_next    = snap2_reg;
                                    stored_next = win_shift[15:0];
                                end
                                32'(LEN_FLOOR + 3):
                                begin
                                    crc_next    = snap3_reg;
                                    stored_next = {win_shift[7:0], 8'h00};
                                end
                                default:
                                begin
                                    crc_next    = crc_step;
                                    stored_next = 16'h0000;
                                end
                            endcase
                        end
                        else
                        begin
                            push.valid             = 1'b1;
                            push.data.kind         = 1'b1;
                            push.data.frame_length = win_shift;
                            biw_next               = 3'(WIN_BYTES);
                            run_next               = 16'h0000;
                            offset_next = sync_hit ? OFFSET_BITS'(SYNC_END) : '0;
                        end
                    end
                end
                PH_BODY:
                begin
                    if ((off_wide + 33'(CRC_TAIL)) <= len_wide)
                        crc_next = crc_step;
                    if ((off_wide + 33'(STORED_HI)) == len_wide)
                        stored_next[15:8] = in_byte;
                    if ((off_wide + 33'(STORED_LO)) == len_wide)
                        stored_next[7:0] = in_byte;
                    push.valid              = 1'b1;
                    push.data.kind          = 1'b0;
                    push.data.out_byte      = in_byte;
                    push.data.byte_offset   = off_wide[OFFSET_OUT_W-1:0];
                    push.data.last_of_frame = is_last;
                    push.data.crc_ok        = is_last && (crc_next == stored_next);
                    push.data.frame_length  = length_reg;
                    if (is_last)
                    begin
                        window_next = '0;
                        biw_next    = '0;
                        offset_next = '0;
                    end
                    else
                    begin
                        offset_next = offset_inc;
                    end
                end
                default:
                begin
                    window_next = win_shift;
                    biw_next    = biw_sat;
                    if (biw_sat >= 3'(WIN_BYTES) && sync_hit)
                    begin
                        offset_next = OFFSET_BITS'(SYNC_END);
                        run_next    = 16'h0000;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= '0;
            length_reg <= '0;
            offset_reg <= '0;
            crc_reg    <= '0;
            stored_reg <= '0;
            biw_reg    <= '0;
            run_reg    <= '0;
            snap1_reg  <= '0;
            snap2_reg  <= '0;
            snap3_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            length_reg <= length_next;
            offset_reg <= offset_next;
            crc_reg    <= crc_next;
            stored_reg <= stored_next;
            biw_reg    <= biw_next;
            run_reg    <= run_next;
            snap1_reg  <= snap1_next;
            snap2_reg  <= snap2_next;
            snap3_reg  <= snap3_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/slcd_queue.sv]
// Result queue between the deframer front end and the output stream.
// Short FIFO of result records; head is presented to the output side.
// Depends on slcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcd_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire slcd_pkg::slcd_push_t   push,
    output logic                        space,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output slcd_pkg::slcd_result_t      out_data
);
    import slcd_pkg::*;

    slcd_result_t        q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    assign space     = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push.valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            q_mem[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/slcd_checker.sv]
// Port-level checker for sync_length_crc_deframer, bound to the top level.
// Depends on nothing beyond the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module slcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    logic [19:0] len_minus_one;
    assign len_minus_one = m_tdata[48:29] - 20'd1;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("output changed while stalled");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata[28:0] == 29'd0))
        else $error("rejected length with body fields set");

    a_crc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[28] |-> m_tlast && !m_tuser)
        else $error("crc_ok outside last byte");

    a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[27:8] == len_minus_one)
        else $error("last byte offset does not match frame length");

endmodule

bind sync_length_crc_deframer slcd_checker u_slcd_checker (.*);

`default_nettype wire
